/* hw/rtl/lspp_pkg.sv */
// Package: shared types and constants of the light status packet parser.
`default_nettype none

package lspp_pkg;

    localparam int unsigned NUM_CHANNELS = 5;

    localparam logic [7:0] LEAD_BYTE      = 8'hD2;
    localparam logic [7:0] STATUS_BYTE    = 8'hB0;
    localparam logic [7:0] ACK_BYTE_A     = 8'hA1;
    localparam logic [7:0] ACK_BYTE_B     = 8'hA6;
    localparam logic [7:0] MARKER_START   = 8'h02;
    localparam logic [7:0] MARKER_END     = 8'hF5;
    localparam logic [7:0] LEVEL_TAG      = 8'h18;
    localparam logic [7:0] FIRST_CHAN_ID  = 8'h03;
    localparam logic [7:0] LEVEL_LIMIT    = 8'd100;
    localparam logic [7:0] MODE_BYTE_MAN  = 8'h00;
    localparam logic [7:0] MODE_BYTE_AUTO = 8'h01;

    localparam logic [3:0] POS_HEAD0   = 4'd0;
    localparam logic [3:0] POS_HEAD1   = 4'd1;
    localparam logic [3:0] POS_MODE    = 4'd5;
    localparam logic [3:0] POS_SAT     = 4'd8;
    localparam logic [3:0] ACK_MIN_LEN = 4'd3;

    // reciprocal of 5 in 10 fractional bits, exact for sums below 1024
    localparam logic [7:0] RECIP5      = 8'd205;
    localparam int unsigned RECIP_SHIFT = 10;
    localparam logic [9:0] ROUND_BIAS  = 10'd2;

    typedef enum logic [1:0] {
        MODE_MANUAL  = 2'd0,
        MODE_AUTO    = 2'd1,
        MODE_UNKNOWN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_ID     = 2'd1,
        PH_TAG    = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef struct packed {
        logic step;
        logic clear;
    } chan_ctrl_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic       status_valid;
        logic [1:0] mode;
        logic [6:0] pink_level;
        logic [6:0] blue_level;
        logic [6:0] cold_white_level;
        logic [6:0] white_level;
        logic [6:0] warm_white_level;
        logic [6:0] average_level;
        logic       ack_valid;
    } out_t;

endpackage

`default_nettype wire

/* hw/rtl/lspp_channel.sv */
// Per-channel tracker: finds id, level tag and level byte after the marker.
`default_nettype none

module lspp_channel (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lspp_pkg::chan_ctrl_t  ctrl,
    input  wire logic [7:0]            chan_id,
    input  wire logic [7:0]            byte_value,
    output logic [6:0]                 level_next
);

    lspp_pkg::phase_t phase_reg, phase_next;
    logic [6:0]       value_reg, value_next;

    always_comb
    begin
        phase_next = phase_reg;
        value_next = value_reg;
        if (ctrl.step)
        begin
            case (phase_reg)
                lspp_pkg::PH_SEARCH:
                begin
                    if (byte_value == chan_id)
                        phase_next = lspp_pkg::PH_ID;
                end
                lspp_pkg::PH_ID:
                begin
                    phase_next = (byte_value == lspp_pkg::LEVEL_TAG) ?
                                 lspp_pkg::PH_TAG : lspp_pkg::PH_DONE;
                end
                lspp_pkg::PH_TAG:
                begin
                    value_next = (byte_value > lspp_pkg::LEVEL_LIMIT) ?
                                 lspp_pkg::LEVEL_LIMIT[6:0] : byte_value[6:0];
                    phase_next = lspp_pkg::PH_DONE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= lspp_pkg::PH_SEARCH;
            value_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            phase_reg <= lspp_pkg::PH_SEARCH;
            value_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            value_reg <= value_next;
        end
    end

    // the closing byte may itself carry the level, so report the updated value
    assign level_next = value_next;

endmodule

`default_nettype wire

/* hw/rtl/light_status_packet_parser_core.sv */
// Top level: byte-serial parser of light status and acknowledgement replies.
`default_nettype none

// Takes one packet byte per beat on the input channel, with last_byte set on
// the closing byte, and delivers exactly one result beat per packet. The block
// sustains one byte per clock unless a closing byte waits; a byte goes through
// an input register and then through the header, marker and channel trackers
// into the result register, so the result beat is valid in the cycle after its
// closing byte is parsed. A closing byte waits in the input register while an
// earlier result is still held; other bytes never wait. Throughput is set by
// the single tracker update per byte. A status result is valid for a packet
// that starts D2 B0, is at least eight bytes long and carries a 02 F5 marker;
// levels come from "id 18 value" triplets after the first marker (ids 03..07,
// clamped to 100), and an invalid status gives all zero status fields.
// ack_valid flags D2 A1 / D2 A6 packets of three or more bytes. All parsing
// state clears after the closing byte; there is no configuration.
module light_status_packet_parser_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire lspp_pkg::in_t  in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output lspp_pkg::out_t      out_data
);

    // ---------------- input register stage ----------------
    logic          s1_valid_reg;
    lspp_pkg::in_t s1_data_reg;
    logic          s1_go;      // stage-1 beat consumed by the parser
    logic          s1_close;   // consumed beat closes a packet

    logic           out_valid_reg;
    lspp_pkg::out_t out_data_reg;

    // a non-closing byte never needs the result slot, so only a closing
    // byte waits on the output register
    assign s1_go    = s1_valid_reg &&
                      (!s1_data_reg.last_byte || !out_valid_reg || out_ready);
    assign s1_close = s1_go && s1_data_reg.last_byte;
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            s1_data_reg <= in_data;
    end

    // ---------------- packet-level trackers ----------------
    logic [7:0]       b;
    logic [3:0]       pos_reg, pos_next;
    logic             lead_ok_reg, lead_ok_next;
    logic             status_hdr_reg, status_hdr_next;
    logic             ack_hdr_reg, ack_hdr_next;
    lspp_pkg::mode_t  mode_reg, mode_next;
    logic             prev_start_reg, prev_start_next;
    logic             marker_reg, marker_next;

    assign b = s1_data_reg.byte_value;

    always_comb
    begin
        lead_ok_next    = lead_ok_reg;
        status_hdr_next = status_hdr_reg;
        ack_hdr_next    = ack_hdr_reg;
        mode_next       = mode_reg;
        marker_next     = marker_reg;
        prev_start_next = prev_start_reg;
        pos_next        = pos_reg;
        if (s1_go)
        begin
            if (pos_reg == lspp_pkg::POS_HEAD0)
                lead_ok_next = (b == lspp_pkg::LEAD_BYTE);
            else if (pos_reg == lspp_pkg::POS_HEAD1)
            begin
                status_hdr_next = lead_ok_reg && (b == lspp_pkg::STATUS_BYTE);
                ack_hdr_next    = lead_ok_reg &&
                                  ((b == lspp_pkg::ACK_BYTE_A) ||
                                   (b == lspp_pkg::ACK_BYTE_B));
            end
            else if (pos_reg == lspp_pkg::POS_MODE)
            begin
                if (b == lspp_pkg::MODE_BYTE_MAN)
                    mode_next = lspp_pkg::MODE_MANUAL;
                else if (b == lspp_pkg::MODE_BYTE_AUTO)
                    mode_next = lspp_pkg::MODE_AUTO;
                else
                    mode_next = lspp_pkg::MODE_UNKNOWN;
            end

            // only the first marker counts; channels search from the next byte
            if (!marker_reg && prev_start_reg && (b == lspp_pkg::MARKER_END))
                marker_next = 1'b1;
            prev_start_next = (b == lspp_pkg::MARKER_START);

            if (pos_reg < lspp_pkg::POS_SAT)
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            lead_ok_reg    <= 1'b0;
            status_hdr_reg <= 1'b0;
            ack_hdr_reg    <= 1'b0;
            mode_reg       <= lspp_pkg::MODE_UNKNOWN;
            prev_start_reg <= 1'b0;
            marker_reg     <= 1'b0;
        end
        else if (s1_close)
        begin
            pos_reg        <= '0;
            lead_ok_reg    <= 1'b0;
            status_hdr_reg <= 1'b0;
            ack_hdr_reg    <= 1'b0;
            mode_reg       <= lspp_pkg::MODE_UNKNOWN;
            prev_start_reg <= 1'b0;
            marker_reg     <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            lead_ok_reg    <= lead_ok_next;
            status_hdr_reg <= status_hdr_next;
            ack_hdr_reg    <= ack_hdr_next;
            mode_reg       <= mode_next;
            prev_start_reg <= prev_start_next;
            marker_reg     <= marker_next;
        end
    end

    // ---------------- channel trackers ----------------
    lspp_pkg::chan_ctrl_t chan_ctrl;
    logic [6:0]           level [lspp_pkg::NUM_CHANNELS];

    // trackers see bytes only once the marker was seen on an earlier byte
    assign chan_ctrl.step  = s1_go && marker_reg;
    assign chan_ctrl.clear = s1_close;

    for (genvar ch = 0; ch < lspp_pkg::NUM_CHANNELS; ch++)
    begin : g_chan
        lspp_channel u_chan (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (chan_ctrl),
            .chan_id    (lspp_pkg::FIRST_CHAN_ID + 8'(ch)),
            .byte_value (b),
            .level_next (level[ch])
        );
    end

    // ---------------- result ----------------
    logic           status_ok;
    logic           ack_ok;
    logic [9:0]     level_sum;
    logic [17:0]    avg_prod;
    lspp_pkg::out_t result;

    assign status_ok = status_hdr_next && (pos_next >= lspp_pkg::POS_SAT) && marker_next;
    assign ack_ok    = ack_hdr_next && (pos_next >= lspp_pkg::ACK_MIN_LEN);

    always_comb
    begin
        level_sum = lspp_pkg::ROUND_BIAS;
        for (int i = 0; i < lspp_pkg::NUM_CHANNELS; i++)
            level_sum = level_sum + {3'b000, level[i]};
    end

    // (sum + 2) / 5 as a reciprocal multiply
    assign avg_prod = level_sum * lspp_pkg::RECIP5;

    always_comb
    begin
        result                  = '0;
        result.ack_valid        = ack_ok;
        if (status_ok)
        begin
            result.status_valid     = 1'b1;
            result.mode             = mode_next;
            result.pink_level       = level[0];
            result.blue_level       = level[1];
            result.cold_white_level = level[2];
            result.white_level      = level[3];
            result.warm_white_level = level[4];
            result.average_level    = avg_prod[lspp_pkg::RECIP_SHIFT +: 7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_close)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_close)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- assertions ----------------
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= lspp_pkg::POS_SAT)
        else $error("byte position beyond saturation");

    a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        s1_close |=> (pos_reg == '0) && !marker_reg)
        else $error("packet state not cleared after closing beat");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.status_valid) |->
        (out_data.mode == '0) && (out_data.average_level == '0) &&
        (out_data.pink_level == '0))
        else $error("status fields nonzero on invalid status");

    a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.average_level <= lspp_pkg::LEVEL_LIMIT[6:0]))
        else $error("average level above limit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !s1_close)
        else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* tb/tb_light_status_packet_parser_core.sv */
// Self-checking testbench of the light status packet parser core.
module tb_light_status_packet_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Run guard: the slowest correct run is ~1.7k beats with random sender gaps,
    // plus a few hundred result beats behind the worst receiver stalls. This
    // limit is many times that.
    localparam int CYCLE_LIMIT = 400000;

    // Channel ids, in result order.
    localparam logic [7:0] PINK_ID  = lspp_pkg::FIRST_CHAN_ID;
    localparam logic [7:0] BLUE_ID  = lspp_pkg::FIRST_CHAN_ID + 8'd1;
    localparam logic [7:0] COLD_ID  = lspp_pkg::FIRST_CHAN_ID + 8'd2;
    localparam logic [7:0] WHITE_ID = lspp_pkg::FIRST_CHAN_ID + 8'd3;
    localparam logic [7:0] WARM_ID  = lspp_pkg::FIRST_CHAN_ID + 8'd4;

    // Receiver stall patterns.
    typedef enum int {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } ready_mode_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    lspp_pkg::in_t   in_data   = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    lspp_pkg::out_t  out_data;

    always #2 clk = ~clk;

    light_status_packet_parser_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Packet decoder mirror: our own copy of the parse state, advanced once
    // per accepted input beat. The closing beat pushes the decoded result.
    // ------------------------------------------------------------------
    logic [3:0]       seen_count;   // bytes seen, saturates at POS_SAT
    logic             lead_ok;
    logic             status_hdr_ok;
    logic             ack_hdr_ok;
    lspp_pkg::mode_t  mode_sel;
    logic             prev_marker_start;
    logic             marker_found;
    lspp_pkg::phase_t chan_phase [lspp_pkg::NUM_CHANNELS];
    logic [6:0]       chan_level [lspp_pkg::NUM_CHANNELS];

    lspp_pkg::out_t decoded_q [$];  // decoded results not yet seen at the output
    logic [7:0]     pkt_q [$];      // bytes of the packet being sent

    int error_count   = 0;
    int beat_count    = 0;
    int packet_count  = 0;
    int status_count  = 0;
    int ack_count     = 0;
    int cycle_count   = 0;
    int burst_left    = 0;

    ready_mode_t ready_mode = RDY_ALWAYS;
    int          ready_left = 0;

    function automatic void clear_tracker();
        int c;
        seen_count        = '0;
        lead_ok           = 1'b0;
        status_hdr_ok     = 1'b0;
        ack_hdr_ok        = 1'b0;
        mode_sel          = lspp_pkg::MODE_UNKNOWN;
        prev_marker_start = 1'b0;
        marker_found      = 1'b0;
        for (c = 0; c < lspp_pkg::NUM_CHANNELS; c++)
        begin
            chan_phase[c] = lspp_pkg::PH_SEARCH;
            chan_level[c] = '0;
        end
    endfunction

    function automatic void decode_byte(lspp_pkg::in_t beat);
        logic [7:0]     b;
        logic [7:0]     id;
        logic           status_ok;
        logic           ack_ok;
        int             sum;
        int             c;
        lspp_pkg::out_t res;
        b = beat.byte_value;

        // header and mode bytes sit at fixed positions
        if (seen_count == lspp_pkg::POS_HEAD0)
            lead_ok = (b == lspp_pkg::LEAD_BYTE);
        else if (seen_count == lspp_pkg::POS_HEAD1)
        begin
            status_hdr_ok = lead_ok && (b == lspp_pkg::STATUS_BYTE);
            ack_hdr_ok    = lead_ok && (b == lspp_pkg::ACK_BYTE_A ||
                                        b == lspp_pkg::ACK_BYTE_B);
        end
        else if (seen_count == lspp_pkg::POS_MODE)
            mode_sel = (b == lspp_pkg::MODE_BYTE_MAN)  ? lspp_pkg::MODE_MANUAL :
                       (b == lspp_pkg::MODE_BYTE_AUTO) ? lspp_pkg::MODE_AUTO :
                                                         lspp_pkg::MODE_UNKNOWN;

        // channels only look at bytes after the first marker
        if (marker_found)
        begin
            for (c = 0; c < lspp_pkg::NUM_CHANNELS; c++)
            begin
                id = lspp_pkg::FIRST_CHAN_ID + 8'(c);
                case (chan_phase[c])
                    lspp_pkg::PH_SEARCH:
                        if (b == id) chan_phase[c] = lspp_pkg::PH_ID;
                    lspp_pkg::PH_ID:
                        chan_phase[c] = (b == lspp_pkg::LEVEL_TAG) ?
                                        lspp_pkg::PH_TAG : lspp_pkg::PH_DONE;
                    lspp_pkg::PH_TAG:
                    begin
                        chan_level[c] = (b > lspp_pkg::LEVEL_LIMIT) ?
                                        7'(lspp_pkg::LEVEL_LIMIT) : b[6:0];
                        chan_phase[c] = lspp_pkg::PH_DONE;
                    end
                    default: ;
                endcase
            end
        end
        else if (prev_marker_start && b == lspp_pkg::MARKER_END)
            marker_found = 1'b1;
        prev_marker_start = (b == lspp_pkg::MARKER_START);

        if (seen_count < lspp_pkg::POS_SAT)
            seen_count++;

        if (!beat.last_byte)
            return;

        status_ok = status_hdr_ok && (seen_count >= lspp_pkg::POS_SAT) && marker_found;
        ack_ok    = ack_hdr_ok && (seen_count >= lspp_pkg::ACK_MIN_LEN);

        // invalid status zeroes every status field
        res = '0;
        sum = 0;
        res.status_valid = status_ok;
        res.mode         = status_ok ? mode_sel : lspp_pkg::MODE_MANUAL;
        if (status_ok)
        begin
            res.pink_level       = chan_level[0];
            res.blue_level       = chan_level[1];
            res.cold_white_level = chan_level[2];
            res.white_level      = chan_level[3];
            res.warm_white_level = chan_level[4];
            for (c = 0; c < lspp_pkg::NUM_CHANNELS; c++)
                sum += chan_level[c];
            res.average_level = 7'((sum + 2) / 5);
        end
        res.ack_valid = ack_ok;
        decoded_q.push_back(res);

        packet_count++;
        if (status_ok) status_count++;
        if (ack_ok)    ack_count++;
        clear_tracker();
    endfunction

    // ------------------------------------------------------------------
    // Mismatch reporting and the result checker.
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Every accepted result beat is matched against the oldest decoded result.
    always @(posedge clk)
    begin : result_check
        lspp_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_q.size() == 0)
                report_error("result beat with nothing expected");
            else
            begin
                want = decoded_q.pop_front();
                check_field("status_valid", 8'(out_data.status_valid),
                            8'(want.status_valid));
                check_field("mode", 8'(out_data.mode), 8'(want.mode));
                check_field("pink_level", 8'(out_data.pink_level),
                            8'(want.pink_level));
                check_field("blue_level", 8'(out_data.blue_level),
                            8'(want.blue_level));
                check_field("cold_white_level", 8'(out_data.cold_white_level),
                            8'(want.cold_white_level));
                check_field("white_level", 8'(out_data.white_level),
                            8'(want.white_level));
                check_field("warm_white_level", 8'(out_data.warm_white_level),
                            8'(want.warm_white_level));
                check_field("average_level", 8'(out_data.average_level),
                            8'(want.average_level));
                check_field("ack_valid", 8'(out_data.ack_valid),
                            8'(want.ack_valid));
            end
        end
    end

    // Receiver back-pressure: a pattern picked for a random stretch, then
    // another one. Always-ready stretches give runs with no stall at all.
    always @(negedge clk)
    begin : ready_pattern
        if (ready_left == 0)
        begin
            ready_mode = ready_mode_t'($urandom_range(3));
            ready_left = $urandom_range(16, 96);
        end
        else
            ready_left--;
        case (ready_mode)
            RDY_ALWAYS:  out_ready <= 1'b1;
            RDY_COIN:    out_ready <= 1'($urandom_range(1));
            RDY_SPARSE:  out_ready <= ($urandom_range(3) == 0);
            default:     out_ready <= ((cycle_count % 5) < 2);
        endcase
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, decoded_q.size());
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts of beats with random idle gaps; gaps are independent
    // of packet boundaries so they land on every byte position.
    // ------------------------------------------------------------------
    task automatic idle_gap(input int cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        in_data  <= 9'($urandom);   // junk while idle
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic send_beat(input logic [7:0] value, input logic last);
        lspp_pkg::in_t beat;
        beat.byte_value = value;
        beat.last_byte  = last;
        if (burst_left == 0)
        begin
            idle_gap($urandom_range(1, 8));
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        decode_byte(beat);
        beat_count++;
        burst_left--;
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt_q.size(); i++)
            send_beat(pkt_q[i], i == pkt_q.size() - 1);
    endtask

    // ------------------------------------------------------------------
    // Packet builders.
    // ------------------------------------------------------------------
    function automatic logic [7:0] level_byte();
        case ($urandom_range(3))
            0: return 8'($urandom_range(0, 100));
            1:
            begin
                // around the clamp and the 7-bit edge
                case ($urandom_range(6))
                    0: return 8'd0;
                    1: return 8'd99;
                    2: return 8'd100;
                    3: return 8'd101;
                    4: return 8'd127;
                    5: return 8'd128;
                    default: return 8'd255;
                endcase
            end
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly well-formed status replies with random content; some with a bad
    // header, a broken marker, id without tag, noise, or cut short.
    task automatic build_status_packet();
        int order [lspp_pkg::NUM_CHANNELS];
        int i;
        int j;
        int tmp;
        int keep;
        pkt_q.delete();
        pkt_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : lspp_pkg::LEAD_BYTE);
        pkt_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : lspp_pkg::STATUS_BYTE);
        repeat (3) pkt_q.push_back(8'($urandom));
        case ($urandom_range(2))
            0:       pkt_q.push_back(lspp_pkg::MODE_BYTE_MAN);
            1:       pkt_q.push_back(lspp_pkg::MODE_BYTE_AUTO);
            default: pkt_q.push_back(8'($urandom));
        endcase
        repeat ($urandom_range(0, 2)) pkt_q.push_back(8'($urandom));
        pkt_q.push_back(lspp_pkg::MARKER_START);
        pkt_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : lspp_pkg::MARKER_END);

        for (i = 0; i < lspp_pkg::NUM_CHANNELS; i++)
            order[i] = i;
        for (i = lspp_pkg::NUM_CHANNELS - 1; i > 0; i--)
        begin
            j        = $urandom_range(i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < lspp_pkg::NUM_CHANNELS; i++)
        begin
            tmp = $urandom_range(9);
            if (tmp < 7)
            begin
                pkt_q.push_back(lspp_pkg::FIRST_CHAN_ID + 8'(order[i]));
                pkt_q.push_back(lspp_pkg::LEVEL_TAG);
                pkt_q.push_back(level_byte());
            end
            else if (tmp == 7)
            begin
                // id followed by a random byte, almost never the tag
                pkt_q.push_back(lspp_pkg::FIRST_CHAN_ID + 8'(order[i]));
                pkt_q.push_back(8'($urandom));
            end
            if ($urandom_range(4) == 0)
                pkt_q.push_back(8'($urandom));
        end

        if ($urandom_range(6) == 0)
        begin
            keep = $urandom_range(1, pkt_q.size());
            while (pkt_q.size() > keep)
                void'(pkt_q.pop_back());
        end
    endtask

    // Acknowledgements and near misses of one to six bytes.
    task automatic build_ack_packet();
        pkt_q.delete();
        pkt_q.push_back(($urandom_range(9) == 0) ? 8'($urandom) : lspp_pkg::LEAD_BYTE);
        if ($urandom_range(7) != 0)
        begin
            case ($urandom_range(3))
                0:       pkt_q.push_back(lspp_pkg::ACK_BYTE_A);
                1:       pkt_q.push_back(lspp_pkg::ACK_BYTE_B);
                2:       pkt_q.push_back(lspp_pkg::STATUS_BYTE);
                default: pkt_q.push_back(8'($urandom));
            endcase
            repeat ($urandom_range(0, 4)) pkt_q.push_back(8'($urandom));
        end
    endtask

    // Random garbage packets, now and then opening with the lead byte.
    task automatic build_noise_packet();
        int n;
        pkt_q.delete();
        n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
        repeat (n) pkt_q.push_back(8'($urandom));
        if ($urandom_range(3) == 0)
            pkt_q[0] = lspp_pkg::LEAD_BYTE;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Hand-built packets: full status with clamp, id without tag, a channel
    // id doubling as another channel's value, id at the close, a minimum
    // length manual status with id plus tag at the close, a single byte
    // packet and a three byte acknowledgement.
    task automatic test_directed();
        // auto mode; pink 255 clamps to 100, blue id without tag, cold 100,
        // white takes the warm id as value, warm id closes the packet
        pkt_q = {lspp_pkg::LEAD_BYTE, lspp_pkg::STATUS_BYTE, lspp_pkg::MARKER_START,
                 lspp_pkg::MARKER_END, BLUE_ID, lspp_pkg::MODE_BYTE_AUTO, PINK_ID,
                 lspp_pkg::LEVEL_TAG, 8'hFF, COLD_ID, lspp_pkg::LEVEL_TAG, 8'd100,
                 WHITE_ID, lspp_pkg::LEVEL_TAG, WARM_ID};
        send_packet();
        // eight bytes, manual, warm id and tag end the packet
        pkt_q = {lspp_pkg::LEAD_BYTE, lspp_pkg::STATUS_BYTE, lspp_pkg::MARKER_START,
                 lspp_pkg::MARKER_END, 8'h00, lspp_pkg::MODE_BYTE_MAN, WARM_ID,
                 lspp_pkg::LEVEL_TAG};
        send_packet();
        pkt_q = {8'hFF};
        send_packet();
        pkt_q = {lspp_pkg::LEAD_BYTE, lspp_pkg::ACK_BYTE_B, 8'h00};
        send_packet();
    endtask

    task automatic test_random_status();
        int stop;
        stop = beat_count + 1000;
        while (beat_count < stop)
        begin
            build_status_packet();
            send_packet();
        end
    endtask

    // Sender holds off until every result is out, then carries on.
    task automatic test_drain_pause();
        repeat (3)
        begin
            build_status_packet();
            send_packet();
        end
        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        build_ack_packet();
        send_packet();
        build_status_packet();
        send_packet();
    endtask

    task automatic test_random_ack();
        int stop;
        stop = beat_count + 350;
        while (beat_count < stop)
        begin
            build_ack_packet();
            send_packet();
        end
    endtask

    task automatic test_random_noise();
        int stop;
        stop = beat_count + 250;
        while (beat_count < stop)
        begin
            build_noise_packet();
            send_packet();
        end
    endtask

    initial
    begin
        clear_tracker();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_status();
        test_drain_pause();
        test_random_ack();
        test_random_noise();

        @(negedge clk);
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        // two-register pipe: keep clocking to catch any stray result beat
        repeat (8) @(posedge clk);

        $display("covered %0d packets in %0d beats: %0d valid status replies, %0d acks",
                 packet_count, beat_count, status_count, ack_count);
        $display("with random sender gaps, receiver stalls and one full drain pause");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lspp_pkg.sv
hw/rtl/lspp_channel.sv
hw/rtl/light_status_packet_parser_core.sv
tb/tb_light_status_packet_parser_core.sv
